// ===== rtl/fixed_width_unsigned_alu_core_macros.svh =====
// Assertion macros used by the unsigned ALU top level.
`ifndef FIXED_WIDTH_UNSIGNED_ALU_CORE_MACROS_SVH
`define FIXED_WIDTH_UNSIGNED_ALU_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FWALU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FWALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fwalu_pkg.sv =====
// Types and constants shared by the unsigned ALU modules.
package fwalu_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_SHL = 4'd5,
		OP_SHR = 4'd6,
		OP_EQ  = 4'd7,
		OP_LT  = 4'd8,
		OP_NOP = 4'd15
	} alu_op_t;

	localparam int OPND_W      = 32;
	localparam int SHIFT_W     = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	typedef struct packed {
		alu_op_t              op;
		logic [OPND_W-1:0]    a;
		logic [OPND_W-1:0]    b;
		logic [SHIFT_W-1:0]   sh;
	} q_entry_t;

endpackage

// ===== rtl/fixed_width_unsigned_alu_core.sv =====
// Top level of the unsigned ALU: front end, queue and execution pipeline.
//
// Usage: one command per input transaction on the s_axis channel, one result per
// transaction on m_axis, in order. s_axis_tuser carries the command code; s_axis_tdata
// carries operand_a, operand_b and shift_count. Codes 9 to 15 give a zero result.
// Operands are reduced to WIDTH bits; results wider than 32 bits are truncated.
// From acceptance a transaction waits in the queue, is loaded into stage zero, and then
// passes through WIDTH pipeline stages that each perform one restoring divide step.
// Throughput is one transaction per cycle for every command while no result is held
// at the output. The front end writes into a four-entry queue, so input keeps flowing
// while a result waits; while a result is held with m_axis_tready low the whole
// execution pipeline holds, the queue fills, and s_axis_tready drops once it is full.
// Reset clears the queue and all pipeline valid bits; no result is pending after it.
`include "fixed_width_unsigned_alu_core_macros.svh"

module fixed_width_unsigned_alu_core #(
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // operand_a[31:0], operand_b[63:32], shift_count[69:64]
	input  logic [3:0]  s_axis_tuser,  // command[3:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // result[31:0], compare_true[32],
	                                   // underflow_clamped[33], divide_by_zero[34]
);

	localparam logic [31:0] RES_ONES = 32'({WIDTH{1'b1}});

	fwalu_pkg::q_entry_t entry;
	fwalu_pkg::q_entry_t q_data;
	logic                q_full;
	logic                q_valid;
	logic                q_pop;
	logic                push;
	logic [31:0]         result;
	logic                compare_true;
	logic                underflow_clamped;
	logic                divide_by_zero;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	fwalu_front u_front (
		.command (s_axis_tuser),
		.payload (s_axis_tdata),
		.entry   (entry)
	);

	fwalu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	fwalu_back #(.WIDTH(WIDTH)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (q_valid),
		.in_data           (q_data),
		.in_pop            (q_pop),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.result            (result),
		.compare_true      (compare_true),
		.underflow_clamped (underflow_clamped),
		.divide_by_zero    (divide_by_zero)
	);

	assign m_axis_tdata = {5'b0, divide_by_zero, underflow_clamped, compare_true, result};

	`FWALU_ASSERT_IMP(a_no_pop_on_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, !q_pop, "queue popped while output stalled")
	`FWALU_ASSERT_IMP(a_dz_all_ones, clk, arst_n, m_axis_tvalid && divide_by_zero, result == RES_ONES, "zero divisor result is not all ones")
	`FWALU_ASSERT_IMP(a_uf_zero, clk, arst_n, m_axis_tvalid && underflow_clamped, result == 32'd0 && !compare_true, "clamped subtract result is not zero")

endmodule

// ===== rtl/fwalu_front.sv =====
// Front end: unpacks an incoming transaction and classifies its command.
module fwalu_front (
	input  logic [3:0]          command,
	input  logic [71:0]         payload,
	output fwalu_pkg::q_entry_t entry
);

	always_comb begin
		case (command)
			fwalu_pkg::OP_ADD: entry.op = fwalu_pkg::OP_ADD;
			fwalu_pkg::OP_SUB: entry.op = fwalu_pkg::OP_SUB;
			fwalu_pkg::OP_MUL: entry.op = fwalu_pkg::OP_MUL;
			fwalu_pkg::OP_DIV: entry.op = fwalu_pkg::OP_DIV;
			fwalu_pkg::OP_MOD: entry.op = fwalu_pkg::OP_MOD;
			fwalu_pkg::OP_SHL: entry.op = fwalu_pkg::OP_SHL;
			fwalu_pkg::OP_SHR: entry.op = fwalu_pkg::OP_SHR;
			fwalu_pkg::OP_EQ:  entry.op = fwalu_pkg::OP_EQ;
			fwalu_pkg::OP_LT:  entry.op = fwalu_pkg::OP_LT;
			default:           entry.op = fwalu_pkg::OP_NOP;
		endcase
		entry.a  = payload[31:0];
		entry.b  = payload[63:32];
		entry.sh = payload[69:64];
	end

endmodule

// ===== rtl/fwalu_queue.sv =====
// Small FIFO between the front end and the execution pipeline.
module fwalu_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fwalu_pkg::q_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output fwalu_pkg::q_entry_t pop_data
);

	fwalu_pkg::q_entry_t                   mem_q [fwalu_pkg::QUEUE_DEPTH];
	logic [fwalu_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [fwalu_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [fwalu_pkg::QUEUE_CNT_W-1:0]     count_q;

	assign full      = (count_q == fwalu_pkg::QUEUE_CNT_W'(fwalu_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fwalu_back.sv =====
// Execution pipeline: one restoring divide step per stage, split multiply, fast ops.
module fwalu_back #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  fwalu_pkg::q_entry_t in_data,
	output logic                in_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         result,
	output logic                compare_true,
	output logic                underflow_clamped,
	output logic                divide_by_zero
);

	localparam int H = (WIDTH + 1) / 2;

	typedef struct packed {
		fwalu_pkg::alu_op_t             op;
		logic [WIDTH-1:0]               num;
		logic [WIDTH-1:0]               b;
		logic [WIDTH-1:0]               rem;
		logic [WIDTH-1:0]               quo;
		logic [WIDTH-1:0]               res;
		logic [WIDTH-1:0]               p_ll;
		logic [WIDTH-1:0]               p_lh;
		logic [WIDTH-1:0]               p_hl;
		logic [fwalu_pkg::SHIFT_W-1:0]  sh;
		logic                           cmp;
		logic                           uf;
		logic                           dz;
	} stage_t;

	stage_t st_s  [0:WIDTH];
	stage_t nxt   [1:WIDTH];
	logic   vld_q [0:WIDTH];
	logic   adv;
	stage_t ld;
	stage_t fin;

	// The whole pipeline moves together unless the output holds an untaken result.
	assign adv       = !vld_q[WIDTH] || out_ready;
	assign in_pop    = adv && in_valid;
	assign out_valid = vld_q[WIDTH];

	always_comb begin
		ld      = '0;
		ld.op   = in_data.op;
		ld.num  = WIDTH'(in_data.a);
		ld.b    = WIDTH'(in_data.b);
		ld.sh   = in_data.sh;
	end

	for (genvar k = 1; k <= WIDTH; k++) begin : g_step
		logic [WIDTH:0]   rsh;
		logic             ge;
		logic [H-1:0]     a_lo, a_hi, b_lo, b_hi;
		logic [2*H-1:0]   pr_ll, pr_lh, pr_hl;
		logic             sh_big;

		assign rsh    = {st_s[k-1].rem, st_s[k-1].num[WIDTH-1]};
		assign ge     = (rsh >= {1'b0, st_s[k-1].b});
		assign a_lo   = st_s[k-1].num[H-1:0];
		assign a_hi   = H'(st_s[k-1].num >> H);
		assign b_lo   = st_s[k-1].b[H-1:0];
		assign b_hi   = H'(st_s[k-1].b >> H);
		assign pr_ll  = a_lo * b_lo;
		assign pr_lh  = a_lo * b_hi;
		assign pr_hl  = a_hi * b_lo;
		assign sh_big = ({1'b0, st_s[k-1].sh} >= 7'(WIDTH));

		always_comb begin
			nxt[k]     = st_s[k-1];
			nxt[k].num = {st_s[k-1].num[WIDTH-2:0], 1'b0};
			nxt[k].rem = ge ? WIDTH'(rsh - {1'b0, st_s[k-1].b}) : rsh[WIDTH-1:0];
			nxt[k].quo = {st_s[k-1].quo[WIDTH-2:0], ge};
			if (k == 1) begin
				nxt[k].p_ll = WIDTH'(pr_ll);
				nxt[k].p_lh = WIDTH'(pr_lh);
				nxt[k].p_hl = WIDTH'(pr_hl);
				case (st_s[k-1].op)
					fwalu_pkg::OP_ADD: nxt[k].res = st_s[k-1].num + st_s[k-1].b;
					fwalu_pkg::OP_SUB: begin
						nxt[k].uf  = (st_s[k-1].b > st_s[k-1].num);
						nxt[k].res = nxt[k].uf ? '0 : st_s[k-1].num - st_s[k-1].b;
					end
					fwalu_pkg::OP_DIV, fwalu_pkg::OP_MOD: begin
						nxt[k].dz  = (st_s[k-1].b == '0);
						nxt[k].res = '1;
					end
					fwalu_pkg::OP_SHL: nxt[k].res = sh_big ? '0 : st_s[k-1].num << st_s[k-1].sh;
					fwalu_pkg::OP_SHR: nxt[k].res = sh_big ? '0 : st_s[k-1].num >> st_s[k-1].sh;
					fwalu_pkg::OP_EQ:  nxt[k].cmp = (st_s[k-1].num == st_s[k-1].b);
					fwalu_pkg::OP_LT:  nxt[k].cmp = (st_s[k-1].num < st_s[k-1].b);
					default:           nxt[k].res = '0;
				endcase
			end
			if (k == 2 && st_s[k-1].op == fwalu_pkg::OP_MUL) begin
				nxt[k].res = st_s[k-1].p_ll + (st_s[k-1].p_lh << H)
					+ (st_s[k-1].p_hl << H);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= ld;
			for (int i = 1; i <= WIDTH; i++) begin
				st_s[i] <= nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= WIDTH; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i <= WIDTH; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_comb begin
		fin = st_s[WIDTH];
		if (fin.op == fwalu_pkg::OP_DIV && !fin.dz) begin
			fin.res = fin.quo;
		end else if (fin.op == fwalu_pkg::OP_MOD && !fin.dz) begin
			fin.res = fin.rem;
		end
	end

	assign result            = 32'(fin.res);
	assign compare_true      = fin.cmp;
	assign underflow_clamped = fin.uf;
	assign divide_by_zero    = fin.dz;

endmodule

// ===== tb/fixed_width_unsigned_alu_core_tb.sv =====
// Self-checking ALU core testbench: directed table, back-pressure run, then random traffic.
`timescale 1ns / 100ps

module fixed_width_unsigned_alu_core_tb;

	localparam int LATENCY = 34;
	localparam int STALL_LIMIT = 5000;
	localparam int N_RANDOM = 1570;
	localparam int N_PRESSURE = 60;

	typedef struct packed {
		logic [31:0] result;
		logic        compare_true;
		logic        underflow_clamped;
		logic        divide_by_zero;
	} alu_result_t;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [5:0]  sh;
		bit          typed;
		alu_result_t res;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	alu_result_t pending_results[$];
	vector_t     dir_rows[$];
	int          failures;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_off;
	int          idle_cycles;

	fixed_width_unsigned_alu_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic alu_result_t compute_alu(logic [3:0] op, logic [31:0] a,
			logic [31:0] b, logic [5:0] sh);
		alu_result_t r;
		logic [63:0] prod;
		r = '0;
		prod = a * b;
		case (op)
			fwalu_pkg::OP_ADD: r.result = a + b;
			fwalu_pkg::OP_SUB: begin
				if (b > a) r.underflow_clamped = 1'b1;
				else r.result = a - b;
			end
			fwalu_pkg::OP_MUL: r.result = prod[31:0];
			fwalu_pkg::OP_DIV, fwalu_pkg::OP_MOD: begin
				if (b == 0) begin
					r.result = '1;
					r.divide_by_zero = 1'b1;
				end else begin
					r.result = (op == fwalu_pkg::OP_DIV) ? a / b : a % b;
				end
			end
			fwalu_pkg::OP_SHL: r.result = (sh >= 32) ? '0 : a << sh;
			fwalu_pkg::OP_SHR: r.result = (sh >= 32) ? '0 : a >> sh;
			fwalu_pkg::OP_EQ: r.compare_true = (a == b);
			fwalu_pkg::OP_LT: r.compare_true = (a < b);
			default: ;
		endcase
		return r;
	endfunction

	function automatic vector_t row(logic [3:0] op, logic [31:0] a, logic [31:0] b,
			logic [5:0] sh, bit typed, alu_result_t res);
		vector_t v;
		v.op = op; v.a = a; v.b = b; v.sh = sh; v.typed = typed; v.res = res;
		return v;
	endfunction

	function automatic void add_row(logic [3:0] op, logic [31:0] a, logic [31:0] b,
			logic [5:0] sh, bit typed, alu_result_t res);
		dir_rows.insert(dir_rows.size(), row(op, a, b, sh, typed, res));
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 15);
			3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Sends one transaction and records its expected result.
	task automatic send_item(vector_t v);
		alu_result_t exp;
		exp = v.typed ? v.res : compute_alu(v.op, v.a, v.b, v.sh);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= v.op;
		s_axis_tdata  <= {2'b00, v.sh, v.b, v.a};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.insert(pending_results.size(), exp);
	endtask

	// Receiver side: random ready, or a long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		alu_result_t got, exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.result            = m_axis_tdata[31:0];
			got.compare_true      = m_axis_tdata[32];
			got.underflow_clamped = m_axis_tdata[33];
			got.divide_by_zero    = m_axis_tdata[34];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failures++;
			end else begin
				exp = pending_results.pop_front();
				if (got.result !== exp.result) begin
					$display("%0t: result expected %h actual %h", $time, exp.result, got.result);
					failures++;
				end
				if (got.compare_true !== exp.compare_true) begin
					$display("%0t: compare_true expected %b actual %b", $time,
						exp.compare_true, got.compare_true);
					failures++;
				end
				if (got.underflow_clamped !== exp.underflow_clamped) begin
					$display("%0t: underflow_clamped expected %b actual %b", $time,
						exp.underflow_clamped, got.underflow_clamped);
					failures++;
				end
				if (got.divide_by_zero !== exp.divide_by_zero) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						exp.divide_by_zero, got.divide_by_zero);
					failures++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAIL fixed_width_unsigned_alu_core");
			$finish;
		end
	end

	initial begin
		vector_t v;
		int k;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;

		add_row(fwalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd1, 6'd0, 1, '{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1,
			'{32'hFFFF_FFFE, 0, 0, 0});
		add_row(fwalu_pkg::OP_SUB, 32'd0, 32'd1, 6'd0, 1, '{32'd0, 0, 1, 0});
		add_row(fwalu_pkg::OP_SUB, 32'd5, 32'd5, 6'd0, 1, '{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_SUB, 32'hFFFF_FFFF, 32'd0, 6'd0, 1,
			'{32'hFFFF_FFFF, 0, 0, 0});
		add_row(fwalu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1,
			'{32'd1, 0, 0, 0});
		add_row(fwalu_pkg::OP_MUL, 32'h1234_5678, 32'h9ABC_DEF0, 6'd0, 0, '0);
		add_row(fwalu_pkg::OP_DIV, 32'd7, 32'd0, 6'd0, 1, '{32'hFFFF_FFFF, 0, 0, 1});
		add_row(fwalu_pkg::OP_MOD, 32'd7, 32'd0, 6'd0, 1, '{32'hFFFF_FFFF, 0, 0, 1});
		add_row(fwalu_pkg::OP_DIV, 32'hFFFF_FFFF, 32'd1, 6'd0, 1,
			'{32'hFFFF_FFFF, 0, 0, 0});
		add_row(fwalu_pkg::OP_DIV, 32'd100, 32'd7, 6'd0, 1, '{32'd14, 0, 0, 0});
		add_row(fwalu_pkg::OP_DIV, 32'd6, 32'hFFFF_FFFF, 6'd0, 1, '{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_MOD, 32'd9, 32'd9, 6'd0, 1, '{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_MOD, 32'hFFFF_FFFF, 32'h8000_0000, 6'd0, 0, '0);
		add_row(fwalu_pkg::OP_SHL, 32'hFFFF_FFFF, 32'd0, 6'd31, 1,
			'{32'h8000_0000, 0, 0, 0});
		add_row(fwalu_pkg::OP_SHL, 32'hFFFF_FFFF, 32'd0, 6'd32, 1, '{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_SHR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1,
			'{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_SHR, 32'h8000_0000, 32'd0, 6'd31, 1, '{32'd1, 0, 0, 0});
		add_row(fwalu_pkg::OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1,
			'{32'd0, 1, 0, 0});
		add_row(fwalu_pkg::OP_EQ, 32'd0, 32'd1, 6'd0, 1, '{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_LT, 32'd0, 32'hFFFF_FFFF, 6'd0, 1, '{32'd0, 1, 0, 0});
		add_row(fwalu_pkg::OP_LT, 32'd3, 32'd3, 6'd0, 1, '{32'd0, 0, 0, 0});
		add_row(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1, '{32'd0, 0, 0, 0});
		add_row(fwalu_pkg::OP_NOP, 32'd1, 32'd0, 6'd63, 1, '{32'd0, 0, 0, 0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i]);

		// Receiver holds off long enough for the pipeline and queue to fill and stall the input.
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int j = 0; j < N_PRESSURE; j++)
				send_item(row(4'($urandom_range(0, 15)), $urandom, $urandom,
					6'($urandom), 1'b0, '0));
		join
		// Sender pauses until everything has drained.
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		for (k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 3) begin
				send_idle_pct = 50; recv_idle_pct = 24;
			end else if (k == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end else if (k == 0) begin
				send_idle_pct = 24; recv_idle_pct = 50;
			end
			v.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			v.a = rand_operand();
			v.b = rand_operand();
			v.sh = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
			v.typed = 0;
			v.res = '0;
			send_item(v);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (failures == 0) begin
			$display("PASS fixed_width_unsigned_alu_core");
		end else begin
			$display("FAIL fixed_width_unsigned_alu_core");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fwalu_pkg.sv
rtl/fwalu_front.sv
rtl/fwalu_queue.sv
rtl/fwalu_back.sv
rtl/fixed_width_unsigned_alu_core.sv
tb/fixed_width_unsigned_alu_core_tb.sv
